[rtl/core/kwm_pkg.sv]
// Shared types, constants and helper functions of the k-way sorted merge.
// Used by kwm_lists, kwm_heap and the top level under rtl/core; depends on nothing else.
`default_nettype none

package kwm_pkg;

	// Sizing of the list storage and the head heap.
	localparam int LISTS      = 8;
	localparam int LIST_DEPTH = 64;

	// Derived widths.
	localparam int LW  = $clog2(LISTS);              // list index
	localparam int HW  = $clog2(LISTS);              // heap slot index
	localparam int SZW = $clog2(LISTS + 1);          // heap entry count
	localparam int CW  = $clog2(2 * LISTS + 1);      // child index before range check
	localparam int SLW = $clog2(LIST_DEPTH);         // slot within one list
	localparam int FCW = $clog2(LIST_DEPTH + 1);     // fill count of one list
	localparam int SAW = $clog2(LISTS * LIST_DEPTH); // list store address

	// Fixed field widths of the stream payload.
	localparam int LN_W   = 3;
	localparam int VAL_W  = 32;
	localparam int DATA_W = 40;

	// Input kinds carried on s_tuser.
	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	// Result kinds carried on m_tuser.
	typedef enum logic [1:0] {
		STAT_APPENDED = 2'd0,
		STAT_POPPED   = 2'd1,
		STAT_DROPPED  = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_UP_CMP,
		S_UP_FIN,
		S_POP_HEAD,
		S_POP_FETCH,
		S_DN_CMP,
		S_EMIT
	} state_t;

	// One heap entry: a list head and the list it belongs to.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [LW-1:0]    list;
	} entry_t;

	localparam int EW = VAL_W + LW;

	// Heap memory access for one cycle.
	typedef struct packed {
		logic          we;
		logic [HW-1:0] waddr;
		entry_t        wdata;
		logic [HW-1:0] ra;
		logic [HW-1:0] rb;
	} heap_cmd_t;

	// The smaller of the two children read for a sift-down step.
	typedef struct packed {
		logic          valid;
		logic [CW-1:0] idx;
		entry_t        ent;
	} child_t;

	// List FIFO operation on one selected list.
	typedef struct packed {
		logic          push;
		logic          pull;
		logic [LW-1:0] list;
	} fifo_cmd_t;

	// Fill state of the selected list.
	typedef struct packed {
		logic full;
		logic empty;
		logic single;
	} fifo_stat_t;

	// True when entry a orders strictly before entry b: signed value first,
	// then the lower list number.
	function automatic logic entry_before(entry_t a, entry_t b);
		logic [VAL_W-1:0] ka;
		logic [VAL_W-1:0] kb;
		ka = {~a.value[VAL_W-1], a.value[VAL_W-2:0]};
		kb = {~b.value[VAL_W-1], b.value[VAL_W-2:0]};
		return (ka < kb) || ((ka == kb) && (a.list < b.list));
	endfunction

endpackage

`default_nettype wire

[rtl/core/kwm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/kwm_lists.sv]
// List FIFOs: per-list fill counts and read positions, and the list store RAM.
// Depends on kwm_pkg and kwm_ram.
`default_nettype none

module kwm_lists import kwm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fifo_cmd_t        cmd,
	input  wire logic [VAL_W-1:0] wr_value,
	output fifo_stat_t            stat,
	output logic      [VAL_W-1:0] rd_value
);

	logic [FCW-1:0] fill_q [LISTS];
	logic [SLW-1:0] rp_q [LISTS];

	logic [FCW-1:0] fill_sel;
	logic [SLW-1:0] rp_sel;
	logic [SLW-1:0] rp_next;
	logic [SLW:0]   tail_sum;
	logic [SLW-1:0] tail;
	logic [SAW-1:0] waddr;
	logic [SAW-1:0] raddr;

	// State of the selected list.
	always_comb begin
		fill_sel    = fill_q[cmd.list];
		rp_sel      = rp_q[cmd.list];
		stat.full   = (fill_sel == FCW'(LIST_DEPTH));
		stat.empty  = (fill_sel == '0);
		stat.single = (fill_sel == FCW'(1));
	end

	// Tail slot for an append and the next head slot for a pop, both wrapped.
	always_comb begin
		tail_sum = (SLW+1)'(rp_sel) + (SLW+1)'(fill_sel);
		if (tail_sum >= (SLW+1)'(LIST_DEPTH)) begin
			tail = SLW'(tail_sum - (SLW+1)'(LIST_DEPTH));
		end else begin
			tail = SLW'(tail_sum);
		end
		if (rp_sel == SLW'(LIST_DEPTH - 1)) begin
			rp_next = '0;
		end else begin
			rp_next = rp_sel + SLW'(1);
		end
		waddr = SAW'(cmd.list) * SAW'(LIST_DEPTH) + SAW'(tail);
		raddr = SAW'(cmd.list) * SAW'(LIST_DEPTH) + SAW'(rp_next);
	end

	// Fill counts and read positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				fill_q[i] <= '0;
				rp_q[i]   <= '0;
			end
		end else if (cmd.push) begin
			fill_q[cmd.list] <= fill_sel + FCW'(1);
		end else if (cmd.pull) begin
			fill_q[cmd.list] <= fill_sel - FCW'(1);
			rp_q[cmd.list]   <= rp_next;
		end
	end

	// Element storage; a pull fetches the element that becomes the new head.
	kwm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (LISTS * LIST_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (waddr),
		.wdata (wr_value),
		.re    (cmd.pull),
		.raddr (raddr),
		.rdata (rd_value)
	);

endmodule

`default_nettype wire

[rtl/core/kwm_heap.sv]
// Head heap storage: two mirrored RAMs give two reads a cycle, plus the
// selection of the smaller child for a sift-down step. Depends on kwm_pkg, kwm_ram.
`default_nettype none

module kwm_heap import kwm_pkg::*; (
	input  wire logic           clk,
	input  wire heap_cmd_t      cmd,
	input  wire logic [CW-1:0]  left_idx,
	input  wire logic [SZW-1:0] size,
	output entry_t              rd_a,
	output entry_t              rd_b,
	output child_t              best
);

	logic [EW-1:0] rdata_a;
	logic [EW-1:0] rdata_b;
	logic [CW-1:0] right_idx;
	logic          left_ok;
	logic          right_ok;
	logic          pick_right;

	// Both copies take every write.
	kwm_ram #(
		.WIDTH (EW),
		.DEPTH (LISTS)
	) u_copy_a (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (cmd.waddr),
		.wdata (cmd.wdata),
		.re    (1'b1),
		.raddr (cmd.ra),
		.rdata (rdata_a)
	);

	kwm_ram #(
		.WIDTH (EW),
		.DEPTH (LISTS)
	) u_copy_b (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (cmd.waddr),
		.wdata (cmd.wdata),
		.re    (1'b1),
		.raddr (cmd.rb),
		.rdata (rdata_b)
	);

	assign rd_a = entry_t'(rdata_a);
	assign rd_b = entry_t'(rdata_b);

	// Pick the smaller of the children that lie inside the heap.
	always_comb begin
		right_idx  = left_idx + CW'(1);
		left_ok    = (left_idx < CW'(size));
		right_ok   = (right_idx < CW'(size));
		pick_right = right_ok && entry_before(rd_b, rd_a);
		best.valid = left_ok;
		best.idx   = pick_right ? right_idx : left_idx;
		best.ent   = pick_right ? rd_b : rd_a;
	end

endmodule

`default_nettype wire

[rtl/core/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge: stream ports, sequencer, output register.
// Depends on kwm_pkg, kwm_lists and kwm_heap.
//
// Usage: each slave transaction is one command. s_tuser = 0 appends the value to
// the tail of list list_number; s_tuser = 1 pops the smallest head over all
// non-empty lists (ties to the lower list). Every command yields exactly one
// master transaction: m_tuser carries the status (appended, popped, append
// dropped because the list is full, pop on empty).
// Timing: commands are handled one at a time. The command is accepted in the
// idle state and dispatched; its result then enters the output register in the
// emit state: directly for a plain or dropped append, an append into an empty
// heap and a pop on empty; after a sift-up for an append that starts a list in
// a non-empty heap; after the head read, a fetch of the list's next element if
// it has one and a sift-down if entries remain, for a pop. The heap RAM read is
// registered, so each heap level costs one read-compare-write step.
// The next command is taken while the previous result waits in the output
// register; a stalled receiver stops the sequencer only when a new result is
// ready and the register is still full.
// Reset: all lists and the heap are empty; nothing needs clearing.
`default_nettype none

module k_way_sorted_merge import kwm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,  // list_number[2:0], value[34:3], zeros
	input  wire logic              s_tuser,  // action[0]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [DATA_W-1:0] m_tdata,  // merged_value[31:0], source_list[34:32],
	                                         // all_drained[35], zeros
	output logic      [1:0]        m_tuser   // status[1:0]
);

	state_t state_q;
	state_t state_d;

	// Latched command.
	logic             act_q;
	logic [LN_W-1:0]  ln_q;
	logic [VAL_W-1:0] val_q;

	// Heap bookkeeping.
	logic [SZW-1:0] size_q;
	logic [SZW-1:0] size_d;
	logic [HW-1:0]  hole_q;
	logic [HW-1:0]  hole_d;
	entry_t         x_q;
	entry_t         x_d;

	// Result being built.
	status_t          res_status_q;
	status_t          res_status_d;
	logic [VAL_W-1:0] res_value_q;
	logic [VAL_W-1:0] res_value_d;
	logic [LN_W-1:0]  res_src_q;
	logic [LN_W-1:0]  res_src_d;
	logic             res_drained_q;
	logic             res_drained_d;

	// Output register.
	logic              m_valid_q;
	logic [DATA_W-1:0] m_data_q;
	logic [1:0]        m_user_q;

	heap_cmd_t        hcmd;
	entry_t           h_rd_a;
	entry_t           h_rd_b;
	child_t           best;
	fifo_cmd_t        fcmd;
	fifo_stat_t       fstat;
	logic [VAL_W-1:0] f_rdata;

	logic          s_acc;
	logic          emit_load;
	logic          ln_ok;
	logic [LW-1:0] ln_idx;
	logic [CW-1:0] left_idx;
	logic [HW-1:0] parent_idx;
	logic          up_move;
	logic          dn_move;
	logic          append_ok;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// Index arithmetic and compare decisions.
	assign ln_ok      = (32'(ln_q) < LISTS);
	assign ln_idx     = LW'(ln_q);
	assign left_idx   = (CW'(hole_q) << 1) + CW'(1);
	assign parent_idx = (hole_q - HW'(1)) >> 1;
	assign up_move    = entry_before(x_q, h_rd_a);
	assign dn_move    = best.valid && entry_before(best.ent, x_q);
	assign append_ok  = ln_ok && !fstat.full;

	// List FIFO control.
	assign fcmd.list = (state_q == S_POP_HEAD) ? h_rd_a.list : ln_idx;
	assign fcmd.push = (state_q == S_DISPATCH) && (act_q == ACT_APPEND) && append_ok;
	assign fcmd.pull = (state_q == S_POP_HEAD);

	kwm_lists u_lists (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (fcmd),
		.wr_value (val_q),
		.stat     (fstat),
		.rd_value (f_rdata)
	);

	kwm_heap u_heap (
		.clk      (clk),
		.cmd      (hcmd),
		.left_idx (left_idx),
		.size     (size_q),
		.rd_a     (h_rd_a),
		.rd_b     (h_rd_b),
		.best     (best)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (act_q == ACT_APPEND) begin
					if (append_ok && fstat.empty && (size_q != '0)) begin
						state_d = S_UP_CMP;
					end else begin
						state_d = S_EMIT;
					end
				end else if (size_q == '0) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_POP_HEAD;
				end
			end
			S_UP_CMP: begin
				if (!up_move) begin
					state_d = S_EMIT;
				end else if (parent_idx == '0) begin
					state_d = S_UP_FIN;
				end
			end
			S_UP_FIN: begin
				state_d = S_EMIT;
			end
			S_POP_HEAD: begin
				if (!fstat.single) begin
					state_d = S_POP_FETCH;
				end else if (size_q == SZW'(1)) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_POP_FETCH: begin
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (!dn_move) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Heap accesses and register updates of each state.
	always_comb begin
		hcmd          = '0;
		size_d        = size_q;
		hole_d        = hole_q;
		x_d           = x_q;
		res_status_d  = res_status_q;
		res_value_d   = res_value_q;
		res_src_d     = res_src_q;
		res_drained_d = res_drained_q;
		emit_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					res_status_d  = STAT_APPENDED;
					res_value_d   = '0;
					res_src_d     = '0;
					res_drained_d = 1'b0;
				end
			end
			S_DISPATCH: begin
				if (act_q == ACT_APPEND) begin
					if (!append_ok) begin
						res_status_d = STAT_DROPPED;
					end else if (fstat.empty) begin
						// The list gets its first element: insert it at the heap's end.
						x_d.value = val_q;
						x_d.list  = ln_idx;
						hole_d    = HW'(size_q);
						size_d    = size_q + SZW'(1);
						if (size_q == '0) begin
							hcmd.we    = 1'b1;
							hcmd.waddr = '0;
							hcmd.wdata = x_d;
						end else begin
							hcmd.ra = HW'((size_q - SZW'(1)) >> 1);
						end
					end
				end else if (size_q == '0) begin
					res_status_d  = STAT_EMPTY;
					res_drained_d = 1'b1;
				end else begin
					// Fetch the root and the last entry.
					hcmd.ra = '0;
					hcmd.rb = HW'(size_q - SZW'(1));
				end
			end
			S_UP_CMP: begin
				// Move the parent down into the hole, or settle the new entry.
				hcmd.we    = 1'b1;
				hcmd.waddr = hole_q;
				if (up_move) begin
					hcmd.wdata = h_rd_a;
					hole_d     = parent_idx;
					hcmd.ra    = (parent_idx - HW'(1)) >> 1;
				end else begin
					hcmd.wdata = x_q;
				end
			end
			S_UP_FIN: begin
				hcmd.we    = 1'b1;
				hcmd.waddr = hole_q;
				hcmd.wdata = x_q;
			end
			S_POP_HEAD: begin
				res_status_d = STAT_POPPED;
				res_value_d  = h_rd_a.value;
				res_src_d    = LN_W'(h_rd_a.list);
				hole_d       = '0;
				x_d.list     = h_rd_a.list;
				if (fstat.single) begin
					// The list drains: the last entry refills the root.
					size_d        = size_q - SZW'(1);
					x_d           = h_rd_b;
					res_drained_d = (size_q == SZW'(1));
					hcmd.ra       = HW'(1);
					hcmd.rb       = HW'(2);
				end
			end
			S_POP_FETCH: begin
				// The list's next element becomes its head at the root.
				x_d.value = f_rdata;
				hcmd.ra   = HW'(1);
				hcmd.rb   = HW'(2);
			end
			S_DN_CMP: begin
				// Move the smaller child up into the hole, or settle the entry.
				hcmd.we    = 1'b1;
				hcmd.waddr = hole_q;
				if (dn_move) begin
					hcmd.wdata = best.ent;
					hole_d     = HW'(best.idx);
					hcmd.ra    = HW'((best.idx << 1) + CW'(1));
					hcmd.rb    = HW'((best.idx << 1) + CW'(2));
				end else begin
					hcmd.wdata = x_q;
				end
			end
			S_EMIT: begin
				emit_load = !m_valid_q || m_tready;
			end
			default: begin
				hcmd = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			size_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
			if (emit_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			act_q <= s_tuser;
			ln_q  <= s_tdata[LN_W-1:0];
			val_q <= s_tdata[LN_W+VAL_W-1:LN_W];
		end
		hole_q        <= hole_d;
		x_q           <= x_d;
		res_status_q  <= res_status_d;
		res_value_q   <= res_value_d;
		res_src_q     <= res_src_d;
		res_drained_q <= res_drained_d;
		if (emit_load) begin
			m_data_q <= {(DATA_W - VAL_W - LN_W - 1)'(0), res_drained_q, res_src_q, res_value_q};
			m_user_q <= res_status_q;
		end
	end

endmodule

`default_nettype wire

[test/tb_k_way_sorted_merge.sv]
// Self-checking testbench of the k-way sorted merge (min-heap of list heads).
// Drives append and pop commands on the slave stream and checks every result
// against a scoreboard. Depends on kwm_pkg and the k_way_sorted_merge RTL only.
`timescale 1ns / 1ps

module tb_k_way_sorted_merge;
	import kwm_pkg::*;

	// One command as it travels on the slave stream.
	typedef struct {
		logic              action;
		logic [LN_W-1:0]   list_number;
		logic [VAL_W-1:0]  value;
	} merge_cmd_t;

	// One result as it should appear on the master stream.
	typedef struct {
		status_t           status;
		logic [VAL_W-1:0]  merged_value;
		logic [LN_W-1:0]   source_list;
		logic              all_drained;
	} merge_res_t;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int CALM_TAIL       = 60;
	localparam int HOLD_CYCLES     = 300;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [1:0]        m_tuser;

	merge_cmd_t        cmd_queue[$];
	merge_res_t        merged_queue[$];
	int                errors   = 0;
	int                taken    = 0;
	int                idle_run = 0;

	// Shadow copy of the list FIFOs used to work out the merged order.
	logic [VAL_W-1:0]  lane_mem [LISTS][LIST_DEPTH];
	int                lane_rd  [LISTS];
	int                lane_cnt [LISTS];

	k_way_sorted_merge u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Work out the result of one accepted command and advance the shadow lists.
	function automatic void merge_predict(input merge_cmd_t c);
		merge_res_t r;
		int         best;
		int         idx;
		r.status       = STAT_APPENDED;
		r.merged_value = '0;
		r.source_list  = '0;
		r.all_drained  = 1'b0;
		best           = -1;
		if (c.action == ACT_APPEND) begin
			idx = c.list_number;
			if (idx >= LISTS || lane_cnt[idx] >= LIST_DEPTH) begin
				r.status = STAT_DROPPED;
			end else begin
				lane_mem[idx][(lane_rd[idx] + lane_cnt[idx]) % LIST_DEPTH] = c.value;
				lane_cnt[idx]++;
			end
		end else begin
			// Scan in ascending list order so that ties stay with the lower list.
			for (int l = 0; l < LISTS; l++) begin
				if (lane_cnt[l] > 0) begin
					if (best < 0 || $signed(lane_mem[l][lane_rd[l]]) <
							$signed(lane_mem[best][lane_rd[best]]))
						best = l;
				end
			end
			if (best < 0) begin
				r.status      = STAT_EMPTY;
				r.all_drained = 1'b1;
			end else begin
				r.status       = STAT_POPPED;
				r.merged_value = lane_mem[best][lane_rd[best]];
				r.source_list  = best[LN_W-1:0];
				lane_rd[best]  = (lane_rd[best] + 1) % LIST_DEPTH;
				lane_cnt[best]--;
				r.all_drained  = 1'b1;
				for (int l = 0; l < LISTS; l++)
					if (lane_cnt[l] > 0)
						r.all_drained = 1'b0;
			end
		end
		merged_queue.push_back(r);
	endfunction

	task automatic add_cmd(input logic act, input int ln, input logic [VAL_W-1:0] v);
		merge_cmd_t c;
		c.action      = act;
		c.list_number = ln[LN_W-1:0];
		c.value       = v;
		cmd_queue.push_back(c);
	endtask

	// Build the stimulus, release reset, and wait for the scoreboard to drain.
	initial begin
		int count;
		int pick;
		int len;
		int ln;
		int step;
		logic [VAL_W-1:0] v;
		bit filled;
		count  = 0;
		filled = 0;
		for (int l = 0; l < LISTS; l++) begin
			lane_rd[l]  = 0;
			lane_cnt[l] = 0;
		end

		// Directed part: empty pop, value extremes, ties, and an unsorted list.
		add_cmd(ACT_POP, 0, '0);
		add_cmd(ACT_APPEND, 0, 32'h7FFF_FFFF);
		add_cmd(ACT_APPEND, 7, 32'h8000_0000);
		add_cmd(ACT_APPEND, 3, 32'h0000_0000);
		add_cmd(ACT_APPEND, 5, 32'hFFFF_FFFF);
		add_cmd(ACT_APPEND, 3, 32'd5);
		add_cmd(ACT_APPEND, 1, 32'h0000_0000);
		add_cmd(ACT_APPEND, 6, 32'hFFFF_FFFF);
		repeat (8) add_cmd(ACT_POP, 0, '0);
		add_cmd(ACT_APPEND, 2, 32'd10);
		add_cmd(ACT_APPEND, 2, 32'd3);
		add_cmd(ACT_APPEND, 4, 32'd7);
		repeat (4) add_cmd(ACT_POP, 7, 32'hFFFF_FFFF);

		// Random part: mostly ascending runs and pop bursts, some noise.
		while (count < 600) begin
			pick = $urandom_range(0, 99);
			if (!filled && count >= 250) begin
				// Overfill one list so that appends get dropped.
				filled = 1;
				ln     = $urandom_range(0, LISTS - 1);
				v      = $urandom_range(0, 1000);
				for (int i = 0; i < LIST_DEPTH + 2; i++)
					add_cmd(ACT_APPEND, ln, v + i);
				count += LIST_DEPTH + 2;
			end else if (pick < 40) begin
				ln   = $urandom_range(0, LISTS - 1);
				len  = $urandom_range(1, 8);
				step = $urandom_range(0, 3);
				if ($urandom_range(0, 1))
					v = $urandom;
				else
					v = int'($urandom_range(0, 20)) - 10;
				for (int i = 0; i < len; i++)
					add_cmd(ACT_APPEND, ln, v + i * step);
				count += len;
			end else if (pick < 75) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					add_cmd(ACT_POP, $urandom_range(0, LISTS - 1), $urandom);
				count += len;
			end else if (pick < 87) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					add_cmd(1'($urandom_range(0, 1)), $urandom_range(0, LISTS - 1), $urandom);
				count += len;
			end else begin
				// Equal values on several lists exercise the tie rule.
				v   = int'($urandom_range(0, 6)) - 3;
				len = $urandom_range(2, LISTS);
				for (int i = 0; i < len; i++)
					add_cmd(ACT_APPEND, $urandom_range(0, LISTS - 1), v);
				count += len;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (cmd_queue.size() == 0 && merged_queue.size() == 0);
		repeat (32) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Driver: offers the pending commands with random gaps.
	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				merge_predict(cmd_queue.pop_front());
				taken++;
			end
			if (s_tvalid && !s_tready) begin
				// Hold the offered transaction until it is taken.
				s_tvalid <= 1'b1;
			end else if (idle_run > 0) begin
				idle_run--;
				s_tvalid <= 1'b0;
			end else if (cmd_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				gap      = $urandom_range(1, 12);
				idle_run = gap - 1;
				s_tvalid <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= cmd_queue[0].action;
				s_tdata  <= {{(DATA_W - VAL_W - LN_W){1'b0}}, cmd_queue[0].value,
					cmd_queue[0].list_number};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result transaction and stalls the receiver at random.
	always @(posedge clk or negedge arst_n) begin
		merge_res_t exp_res;
		int         stall;
		int         hold;
		bit         held;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
			hold  = 0;
			held  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (merged_queue.size() == 0) begin
					$display("%0t: unexpected result status %0d data %h", $time,
						m_tuser, m_tdata);
					errors++;
				end else begin
					exp_res = merged_queue.pop_front();
					if (m_tuser != exp_res.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_res.status, m_tuser);
						errors++;
					end
					if (m_tdata[31:0] != exp_res.merged_value) begin
						$display("%0t: merged_value expected %h actual %h", $time,
							exp_res.merged_value, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[34:32] != exp_res.source_list) begin
						$display("%0t: source_list expected %0d actual %0d", $time,
							exp_res.source_list, m_tdata[34:32]);
						errors++;
					end
					if (m_tdata[35] != exp_res.all_drained) begin
						$display("%0t: all_drained expected %0d actual %0d", $time,
							exp_res.all_drained, m_tdata[35]);
						errors++;
					end
				end
			end
			// Once in the run, hold off long enough for the input to back up.
			if (!held && taken >= 120) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (cmd_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_CYCLES) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

[files.f]
rtl/core/kwm_pkg.sv
rtl/core/kwm_ram.sv
rtl/core/kwm_lists.sv
rtl/core/kwm_heap.sv
rtl/core/k_way_sorted_merge.sv
test/tb_k_way_sorted_merge.sv
